[rtl/rcp_pkg.sv]
`default_nettype none

package rcp_pkg;

  // parser state codes
  localparam logic [4:0] ST_IDLE      = 5'd0;
  localparam logic [4:0] ST_FUNC      = 5'd1;
  localparam logic [4:0] ST_WAIT_X    = 5'd11;
  localparam logic [4:0] ST_X_DIGIT0  = 5'd12;
  localparam logic [4:0] ST_X_DIGIT1  = 5'd13;
  localparam logic [4:0] ST_WAIT_Y    = 5'd14;
  localparam logic [4:0] ST_Y_DIGIT0  = 5'd15;
  localparam logic [4:0] ST_Y_DIGIT1  = 5'd16;
  localparam logic [4:0] ST_TUNE_SEL  = 5'd21;
  localparam logic [4:0] ST_BAL_KEY   = 5'd22;
  localparam logic [4:0] ST_SPD_KEY   = 5'd23;
  localparam logic [4:0] ST_MOTOR     = 5'd31;

  // ASCII codes of the grammar
  localparam logic [7:0] CH_HEADER    = 8'h2A; // '*'
  localparam logic [7:0] CH_DRIVE     = 8'h44; // 'D'
  localparam logic [7:0] CH_TUNE      = 8'h54; // 'T'
  localparam logic [7:0] CH_SWITCH    = 8'h53; // 'S'
  localparam logic [7:0] CH_X         = 8'h58; // 'X'
  localparam logic [7:0] CH_Y         = 8'h59; // 'Y'
  localparam logic [7:0] CH_BALANCE   = 8'h42; // 'B'
  localparam logic [7:0] CH_SPEED     = 8'h53; // 'S'
  localparam logic [7:0] CH_MOTOR_ON  = 8'h43; // 'C'
  localparam logic [7:0] CH_MOTOR_OFF = 8'h63; // 'c'
  localparam logic [7:0] CH_KEY1      = 8'h31;
  localparam logic [7:0] CH_KEY2      = 8'h32;
  localparam logic [7:0] CH_KEY3      = 8'h33;
  localparam logic [7:0] CH_KEY4      = 8'h34;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;

  // gain register indexes
  localparam logic [1:0] GAIN_BAL_KP  = 2'd0;
  localparam logic [1:0] GAIN_BAL_KD  = 2'd1;
  localparam logic [1:0] GAIN_SPD_KP  = 2'd2;
  localparam logic [1:0] GAIN_SPD_KI  = 2'd3;

  localparam int NUM_GAINS = 4;
  localparam logic [7:0] JOY_CENTER = 8'd50;

  // one decoded byte's effect on the architectural state
  typedef struct packed {
    logic       load_first;
    logic       set_drive;
    logic       set_steer;
    logic       gain_en;
    logic [1:0] gain_idx;
    logic [3:0] gain_delta;  // two's complement step
    logic       motor_en;
    logic       motor_val;
    logic       done;
  } rcp_cmd_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // decimal prefix of a two-character field, 0..99
  function automatic logic [6:0] decode_pair(input logic [7:0] c0, input logic [7:0] c1);
    logic [3:0] d0;
    logic [3:0] d1;
    d0 = 4'(c0 - CH_ZERO);
    d1 = 4'(c1 - CH_ZERO);
    if (!is_digit(c0)) return 7'd0;
    if (!is_digit(c1)) return {3'd0, d0};
    return 7'({d0, 3'd0} + {2'd0, d0, 1'b0}) + {3'd0, d1};
  endfunction

endpackage

`default_nettype wire

[rtl/rcp_if.sv]
`default_nettype none

interface rcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rcp_result_if;
  logic              valid;
  logic              ready;
  logic signed [6:0] steer_x;
  logic signed [6:0] drive_y;
  logic signed [15:0] balance_kp;
  logic signed [15:0] balance_kd;
  logic signed [15:0] speed_kp;
  logic signed [15:0] speed_ki;
  logic              motor_on;
  logic              command_done;

  modport source (output valid, output steer_x, output drive_y, output balance_kp,
                  output balance_kd, output speed_kp, output speed_ki,
                  output motor_on, output command_done, input ready);
  modport sink   (input valid, input steer_x, input drive_y, input balance_kp,
                  input balance_kd, input speed_kp, input speed_ki,
                  input motor_on, input command_done, output ready);
endinterface

`default_nettype wire

[rtl/rcp_decoder.sv]
`default_nettype none

module rcp_decoder (
  input  wire logic [4:0]       state,
  input  wire logic [7:0]       rx_byte,
  output logic [4:0]            state_next,
  output rcp_pkg::rcp_cmd_t     cmd
);
  import rcp_pkg::*;

  always_comb begin
    state_next = ST_IDLE;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        state_next = (rx_byte == CH_HEADER) ? ST_FUNC : ST_IDLE;
      end
      ST_FUNC: begin
        case (rx_byte)
          CH_DRIVE:  state_next = ST_WAIT_X;
          CH_TUNE:   state_next = ST_TUNE_SEL;
          CH_SWITCH: state_next = ST_MOTOR;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_WAIT_X: begin
        // wrong letter keeps waiting
        state_next = (rx_byte == CH_X) ? ST_X_DIGIT0 : ST_WAIT_X;
      end
      ST_X_DIGIT0: begin
        cmd.load_first = 1'b1;
        state_next     = ST_X_DIGIT1;
      end
      ST_X_DIGIT1: begin
        cmd.set_drive = 1'b1;
        state_next    = ST_WAIT_Y;
      end
      ST_WAIT_Y: begin
        state_next = (rx_byte == CH_Y) ? ST_Y_DIGIT0 : ST_WAIT_Y;
      end
      ST_Y_DIGIT0: begin
        cmd.load_first = 1'b1;
        state_next     = ST_Y_DIGIT1;
      end
      ST_Y_DIGIT1: begin
        cmd.set_steer = 1'b1;
        cmd.done      = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_TUNE_SEL: begin
        case (rx_byte)
          CH_BALANCE: state_next = ST_BAL_KEY;
          CH_SPEED:   state_next = ST_SPD_KEY;
          default:    state_next = ST_TUNE_SEL;
        endcase
      end
      ST_BAL_KEY, ST_SPD_KEY: begin
        cmd.done = 1'b1;
        case (rx_byte)
          CH_KEY1: begin
            cmd.gain_en    = 1'b1;
            cmd.gain_idx   = (state == ST_BAL_KEY) ? GAIN_BAL_KP : GAIN_SPD_KP;
            cmd.gain_delta = (state == ST_BAL_KEY) ? 4'sd5 : 4'sd4;
          end
          CH_KEY3: begin
            cmd.gain_en    = 1'b1;
            cmd.gain_idx   = (state == ST_BAL_KEY) ? GAIN_BAL_KP : GAIN_SPD_KP;
            cmd.gain_delta = (state == ST_BAL_KEY) ? -4'sd5 : -4'sd4;
          end
          CH_KEY2: begin
            cmd.gain_en    = 1'b1;
            cmd.gain_idx   = (state == ST_BAL_KEY) ? GAIN_BAL_KD : GAIN_SPD_KI;
            cmd.gain_delta = 4'sd1;
          end
          CH_KEY4: begin
            cmd.gain_en    = 1'b1;
            cmd.gain_idx   = (state == ST_BAL_KEY) ? GAIN_BAL_KD : GAIN_SPD_KI;
            cmd.gain_delta = -4'sd1;
          end
          default: cmd.gain_en = 1'b0;
        endcase
        state_next = ST_IDLE;
      end
      ST_MOTOR: begin
        cmd.done = 1'b1;
        if (rx_byte == CH_MOTOR_ON) begin
          cmd.motor_en  = 1'b1;
          cmd.motor_val = 1'b1;
        end else if (rx_byte == CH_MOTOR_OFF) begin
          cmd.motor_en  = 1'b1;
          cmd.motor_val = 1'b0;
        end
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/remote_command_parser_core.sv]
`default_nettype none

// Channel  | Dir | Transaction
// ---------+-----+-------------------------------------------------------------
// rx       | in  | one received command byte (rx_byte)
// result   | out | joystick, four gains, motor switch, command_done per byte
// APB      | in  | writes of the four start gains at 4*i; reads return them
//
// Every byte yields exactly one result. A byte is decoded, the parser state
// and gains are updated, and the result is registered in the cycle it is
// accepted, so one byte per clock is sustained while result is not stalled.
// The result register is the only buffer: rx is ready while it is empty or
// being drained in the same cycle. Synchronous reset returns the parser to
// idle and clears joystick, motor switch, start values and gains.
module remote_command_parser_core #(
  parameter int GAIN_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  rcp_byte_if.sink         rx,
  rcp_result_if.source     result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import rcp_pkg::*;

  // saturation bounds of a gain
  localparam logic signed [32:0] GainMax = (33'sd1 <<< (GAIN_WIDTH - 1)) - 33'sd1;
  localparam logic signed [32:0] GainMin = -GainMax - 33'sd1;

  // architectural state
  logic [4:0]            state;
  logic [7:0]            first_digit;
  logic [6:0]            steer_x_reg;
  logic [6:0]            drive_y_reg;
  logic [GAIN_WIDTH-1:0] gain       [NUM_GAINS];
  logic [GAIN_WIDTH-1:0] start_gain [NUM_GAINS];
  logic                  motor_on_reg;

  // result register
  logic out_valid;

  logic [4:0]  state_next;
  rcp_cmd_t    cmd;
  logic        accept;

  assign accept   = rx.valid && rx.ready;
  assign rx.ready = !out_valid || result.ready;

  rcp_decoder u_decoder (
    .state      (state),
    .rx_byte    (rx.rx_byte),
    .state_next (state_next),
    .cmd        (cmd)
  );

  // joystick: pair value 0..99 mapped around the center
  logic [6:0] pair_value;
  logic [7:0] drive_calc;
  logic [7:0] steer_calc;
  logic [6:0] drive_y_next;
  logic [6:0] steer_x_next;

  assign pair_value   = decode_pair(first_digit, rx.rx_byte);
  assign drive_calc   = {1'b0, pair_value} - JOY_CENTER;
  assign steer_calc   = JOY_CENTER - {1'b0, pair_value};
  assign drive_y_next = cmd.set_drive ? drive_calc[6:0] : drive_y_reg;
  assign steer_x_next = cmd.set_steer ? steer_calc[6:0] : steer_x_reg;

  // one saturating adder shared by all four gains
  logic [GAIN_WIDTH-1:0] gain_sel;
  logic [GAIN_WIDTH:0]   step_sum;
  logic [GAIN_WIDTH-1:0] step_sat;
  logic [GAIN_WIDTH-1:0] gain_next [NUM_GAINS];

  assign gain_sel = gain[cmd.gain_idx];
  assign step_sum = {gain_sel[GAIN_WIDTH-1], gain_sel}
                  + {{(GAIN_WIDTH - 3){cmd.gain_delta[3]}}, cmd.gain_delta};

  always_comb begin
    if (step_sum[GAIN_WIDTH] != step_sum[GAIN_WIDTH-1]) begin
      // overflow: clamp toward the sign of the true sum
      step_sat = step_sum[GAIN_WIDTH] ? {1'b1, {(GAIN_WIDTH - 1){1'b0}}}
                                      : {1'b0, {(GAIN_WIDTH - 1){1'b1}}};
    end else begin
      step_sat = step_sum[GAIN_WIDTH-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_GAINS; i++) begin
      gain_next[i] = (cmd.gain_en && (cmd.gain_idx == 2'(i))) ? step_sat : gain[i];
    end
  end

  logic motor_next;
  assign motor_next = cmd.motor_en ? cmd.motor_val : motor_on_reg;

  // gains leave the block in their low 16 bits of the sign-extended value
  logic [31:0] gain_out [NUM_GAINS];
  always_comb begin
    for (int i = 0; i < NUM_GAINS; i++) begin
      gain_out[i] = 32'(signed'(gain_next[i]));
    end
  end

  // configuration: start value is clamped to the gain range and loads the gain
  logic              cfg_write;
  logic [1:0]        cfg_idx;
  logic signed [32:0] cfg_ext;
  logic signed [32:0] cfg_clamped;
  logic [GAIN_WIDTH-1:0] cfg_gain;

  assign pready      = 1'b1;
  assign cfg_write   = psel && penable && pwrite;
  assign cfg_idx     = paddr[3:2];
  assign cfg_ext     = 33'(signed'(pwdata[15:0]));
  assign cfg_clamped = (cfg_ext > GainMax) ? GainMax :
                       (cfg_ext < GainMin) ? GainMin : cfg_ext;
  assign cfg_gain    = cfg_clamped[GAIN_WIDTH-1:0];
  assign prdata      = 32'(signed'(start_gain[cfg_idx]));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      first_digit  <= '0;
      steer_x_reg  <= '0;
      drive_y_reg  <= '0;
      motor_on_reg <= 1'b0;
      for (int i = 0; i < NUM_GAINS; i++) begin
        gain[i]       <= '0;
        start_gain[i] <= '0;
      end
    end else begin
      if (accept) begin
        state        <= state_next;
        steer_x_reg  <= steer_x_next;
        drive_y_reg  <= drive_y_next;
        motor_on_reg <= motor_next;
        if (cmd.load_first) begin
          first_digit <= rx.rx_byte;
        end
        for (int i = 0; i < NUM_GAINS; i++) begin
          gain[i] <= gain_next[i];
        end
      end
      if (cfg_write) begin
        start_gain[cfg_idx] <= cfg_gain;
        gain[cfg_idx]       <= cfg_gain;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.steer_x      <= steer_x_next;
      result.drive_y      <= drive_y_next;
      result.balance_kp   <= gain_out[GAIN_BAL_KP][15:0];
      result.balance_kd   <= gain_out[GAIN_BAL_KD][15:0];
      result.speed_kp     <= gain_out[GAIN_SPD_KP][15:0];
      result.speed_ki     <= gain_out[GAIN_SPD_KI][15:0];
      result.motor_on     <= motor_next;
      result.command_done <= cmd.done;
    end
  end

  assign result.valid = out_valid;

endmodule

`default_nettype wire

[tb/rcp_check_pkg.sv]
package rcp_check_pkg;
  import rcp_pkg::*;

  localparam int GAIN_MAX    = 32767;
  localparam int GAIN_MIN    = -32768;
  localparam int BAL_KP_STEP = 5;
  localparam int SPD_KP_STEP = 4;
  localparam int FINE_STEP   = 1;
  localparam int SHOW_LIMIT  = 30;

  typedef struct packed {
    logic signed [6:0]  steer_x;
    logic signed [6:0]  drive_y;
    logic signed [15:0] balance_kp;
    logic signed [15:0] balance_kd;
    logic signed [15:0] speed_kp;
    logic signed [15:0] speed_ki;
    logic               motor_on;
    logic               command_done;
  } parser_result_t;

  // Tracks the parser and queues the per-byte result it should report.
  class parser_scoreboard;
    logic [4:0]        cmd_state;
    logic [7:0]        held_char;
    logic signed [6:0] steer;
    logic signed [6:0] drive;
    int                gain [NUM_GAINS];
    logic              motor;
    parser_result_t    expected_q [$];
    int                errors;
    int                n_bytes;
    int                n_checked;
    int                n_done;
    int                n_clamped;

    function new();
      cmd_state = ST_IDLE;
      held_char = '0;
      steer     = '0;
      drive     = '0;
      motor     = 1'b0;
      foreach (gain[i]) gain[i] = 0;
      errors    = 0;
      n_bytes   = 0;
      n_checked = 0;
      n_done    = 0;
      n_clamped = 0;
    endfunction

    function int clamp(int v);
      if (v > GAIN_MAX) return GAIN_MAX;
      if (v < GAIN_MIN) return GAIN_MIN;
      return v;
    endfunction

    function void step_gain(logic [1:0] idx, int delta);
      int v;
      v = gain[idx] + delta;
      if (v != clamp(v)) n_clamped++;
      gain[idx] = clamp(v);
    endfunction

    function bit is_num(logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // decimal prefix of two characters
    function int field_value(logic [7:0] c0, logic [7:0] c1);
      if (!is_num(c0)) return 0;
      if (!is_num(c1)) return int'(c0) - int'(CH_ZERO);
      return (int'(c0) - int'(CH_ZERO)) * 10 + int'(c1) - int'(CH_ZERO);
    endfunction

    // APB write: only the low 16 bits count, gain loads at once
    function void load_gain(logic [1:0] idx, logic [31:0] word);
      gain[idx] = clamp(int'($signed(word[15:0])));
    endfunction

    function void note_byte(logic [7:0] b);
      parser_result_t r;
      logic [4:0]     nxt;
      logic           done;
      nxt  = cmd_state;
      done = 1'b0;
      case (cmd_state)
        ST_IDLE: nxt = (b == CH_HEADER) ? ST_FUNC : ST_IDLE;
        ST_FUNC: begin
          if (b == CH_DRIVE) nxt = ST_WAIT_X;
          else if (b == CH_TUNE) nxt = ST_TUNE_SEL;
          else if (b == CH_SWITCH) nxt = ST_MOTOR;
          else nxt = ST_IDLE;
        end
        // waiting states hold on a wrong letter
        ST_WAIT_X: if (b == CH_X) nxt = ST_X_DIGIT0;
        ST_X_DIGIT0: begin
          held_char = b;
          nxt = ST_X_DIGIT1;
        end
        ST_X_DIGIT1: begin
          drive = 7'(field_value(held_char, b) - int'(JOY_CENTER));
          nxt = ST_WAIT_Y;
        end
        ST_WAIT_Y: if (b == CH_Y) nxt = ST_Y_DIGIT0;
        ST_Y_DIGIT0: begin
          held_char = b;
          nxt = ST_Y_DIGIT1;
        end
        ST_Y_DIGIT1: begin
          steer = 7'(int'(JOY_CENTER) - field_value(held_char, b));
          nxt = ST_IDLE;
          done = 1'b1;
        end
        ST_TUNE_SEL: begin
          if (b == CH_BALANCE) nxt = ST_BAL_KEY;
          else if (b == CH_SPEED) nxt = ST_SPD_KEY;
        end
        ST_BAL_KEY: begin
          case (b)
            CH_KEY1: step_gain(GAIN_BAL_KP, BAL_KP_STEP);
            CH_KEY3: step_gain(GAIN_BAL_KP, -BAL_KP_STEP);
            CH_KEY2: step_gain(GAIN_BAL_KD, FINE_STEP);
            CH_KEY4: step_gain(GAIN_BAL_KD, -FINE_STEP);
            default: ;
          endcase
          nxt = ST_IDLE;
          done = 1'b1;
        end
        ST_SPD_KEY: begin
          case (b)
            CH_KEY1: step_gain(GAIN_SPD_KP, SPD_KP_STEP);
            CH_KEY3: step_gain(GAIN_SPD_KP, -SPD_KP_STEP);
            CH_KEY2: step_gain(GAIN_SPD_KI, FINE_STEP);
            CH_KEY4: step_gain(GAIN_SPD_KI, -FINE_STEP);
            default: ;
          endcase
          nxt = ST_IDLE;
          done = 1'b1;
        end
        ST_MOTOR: begin
          if (b == CH_MOTOR_ON) motor = 1'b1;
          else if (b == CH_MOTOR_OFF) motor = 1'b0;
          nxt = ST_IDLE;
          done = 1'b1;
        end
        default: nxt = ST_IDLE;
      endcase
      cmd_state = nxt;

      r.steer_x      = steer;
      r.drive_y      = drive;
      r.balance_kp   = 16'(gain[GAIN_BAL_KP]);
      r.balance_kd   = 16'(gain[GAIN_BAL_KD]);
      r.speed_kp     = 16'(gain[GAIN_SPD_KP]);
      r.speed_ki     = 16'(gain[GAIN_SPD_KI]);
      r.motor_on     = motor;
      r.command_done = done;
      expected_q.push_back(r);
      n_bytes++;
      if (done) n_done++;
    endfunction

    task report(string what, int got, int want);
      errors++;
      if (errors <= SHOW_LIMIT)
        $display("result %0d: %s got %0d, want %0d", n_checked, what, got, want);
    endtask

    task check_result(parser_result_t got);
      parser_result_t want;
      n_checked++;
      if (expected_q.size() == 0) begin
        report("result with no byte pending", 1, 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.steer_x !== want.steer_x)
        report("steer_x", got.steer_x, want.steer_x);
      if (got.drive_y !== want.drive_y)
        report("drive_y", got.drive_y, want.drive_y);
      if (got.balance_kp !== want.balance_kp)
        report("balance_kp", got.balance_kp, want.balance_kp);
      if (got.balance_kd !== want.balance_kd)
        report("balance_kd", got.balance_kd, want.balance_kd);
      if (got.speed_kp !== want.speed_kp)
        report("speed_kp", got.speed_kp, want.speed_kp);
      if (got.speed_ki !== want.speed_ki)
        report("speed_ki", got.speed_ki, want.speed_ki);
      if (got.motor_on !== want.motor_on)
        report("motor_on", got.motor_on, want.motor_on);
      if (got.command_done !== want.command_done)
        report("command_done", got.command_done, want.command_done);
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

[tb/remote_command_parser_core_test.sv]
module remote_command_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rcp_pkg::*;
  import rcp_check_pkg::*;

  localparam int NUM_PHASES  = 8;
  localparam int PHASE_BYTES = 115;
  // ~1000 bytes plus APB writes, slowest phase included;
  // the limit sits far above that
  localparam int CYCLE_LIMIT = 300000;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rcp_byte_if   rx ();
  rcp_result_if result ();

  parser_scoreboard sb;

  // idle odds in percent, changed per phase
  int gap_pct;
  int stall_pct;
  int cycle_count = 0;

  remote_command_parser_core u_top (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .result (result),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #10 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("remote_command_parser_core: mismatch");
      $finish;
    end
  end

  // Result sink: ready changes on the falling edge, stalls at stall_pct.
  always @(negedge clk) begin
    result.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Every transaction on the result channel is checked against the
  // oldest expectation; values are taken at the rising edge.
  always @(posedge clk) begin
    parser_result_t seen;
    if (!rst && result.valid && result.ready) begin
      seen.steer_x      = result.steer_x;
      seen.drive_y      = result.drive_y;
      seen.balance_kp   = result.balance_kp;
      seen.balance_kd   = result.balance_kd;
      seen.speed_kp     = result.speed_kp;
      seen.speed_ki     = result.speed_ki;
      seen.motor_on     = result.motor_on;
      seen.command_done = result.command_done;
      sb.check_result(seen);
    end
  end

  // The driving tasks all start and end on a falling edge.

  // One byte transaction. valid stays high on exit so back-to-back bytes
  // need no second assignment in the same step.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      rx.valid <= 1'b0;
      @(negedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    sb.note_byte(b);
    @(negedge clk);
  endtask

  task automatic send_string(input string s);
    int k;
    for (k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  // Stop sending and let every outstanding result drain out.
  task automatic drain();
    rx.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // APB write, setup then access; upper data bits are don't-care noise.
  // The bus is returned to idle after the access.
  task automatic write_gain(input logic [1:0] idx, input logic [15:0] value);
    logic [31:0] word;
    word    = {16'($urandom), value};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.load_gain(idx, word);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // mostly a digit, sometimes any byte to hit the short-field decode
  function automatic logic [7:0] digit_char();
    if ($urandom_range(99) < 85) return CH_ZERO + 8'($urandom_range(9));
    return 8'($urandom_range(255));
  endfunction

  // Start gains per phase: pinned to the limits early, then near them or
  // anywhere, so the gain steps saturate often.
  function automatic logic [15:0] start_gain(int phase, int idx);
    case (phase)
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return (idx % 2 == 0) ? 16'h7FFD : 16'h8002;
      3: return 16'h0000;
      default: begin
        case ($urandom_range(2))
          0: return 16'h7FFF - 16'($urandom_range(8));
          1: return 16'h8000 + 16'($urandom_range(8));
          default: return 16'($urandom);
        endcase
      end
    endcase
  endfunction

  // Mostly well-formed commands with random content; the rest are stray
  // bytes, bad function letters, junk in waiting states and odd keys.
  task automatic send_random_command();
    int kind;
    int pick;
    kind = $urandom_range(99);
    if (kind < 12) begin
      send_byte(8'($urandom_range(255)));
      return;
    end
    send_byte(CH_HEADER);
    if (kind < 20) begin
      send_byte(8'($urandom_range(255)));
    end else if (kind < 50) begin
      send_byte(CH_DRIVE);
      if ($urandom_range(7) == 0) send_byte(8'($urandom_range(255)));
      send_byte(CH_X);
      send_byte(digit_char());
      send_byte(digit_char());
      if ($urandom_range(7) == 0) send_byte(8'($urandom_range(255)));
      send_byte(CH_Y);
      send_byte(digit_char());
      send_byte(digit_char());
    end else if (kind < 85) begin
      send_byte(CH_TUNE);
      if ($urandom_range(7) == 0) send_byte(8'($urandom_range(255)));
      send_byte($urandom_range(1) ? CH_BALANCE : CH_SPEED);
      if ($urandom_range(99) < 85) send_byte(CH_KEY1 + 8'($urandom_range(3)));
      else send_byte(8'($urandom_range(255)));
    end else begin
      send_byte(CH_SWITCH);
      pick = $urandom_range(99);
      if (pick < 40) send_byte(CH_MOTOR_ON);
      else if (pick < 80) send_byte(CH_MOTOR_OFF);
      else send_byte(8'($urandom_range(255)));
    end
  endtask

  initial begin
    int phase;
    int first;
    int i;
    bit paused;

    sb           = new();
    gap_pct      = 0;
    stall_pct    = 0;
    rst          = 1'b1;
    rx.valid     = 1'b0;
    rx.rx_byte   = '0;
    result.ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: gains mostly near the limits so the first tuning step clamps.
    write_gain(GAIN_BAL_KP, 16'h7FFF);
    write_gain(GAIN_BAL_KD, 16'h8000);
    write_gain(GAIN_SPD_KP, 16'h7FFE);
    write_gain(GAIN_SPD_KI, 16'h0000);
    // bad function letter drops back to idle
    send_string("*Q");
    // junk while waiting for X and Y holds; non-digit first char gives 0,
    // a digit then a non-digit gives the single digit
    send_string("*D?Xa5!Y7z");
    // joystick extremes: drive +49, steer +50
    send_string("*DX99Y00");
    // junk while waiting for B/S, then a balance kp step into the limit
    send_string("*T?B1");
    // unknown motor letter still ends the command
    send_string("*Sz");
    drain();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      for (i = 0; i < NUM_GAINS; i++) write_gain(2'(i), start_gain(phase, i));
      case (phase % 4)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 73;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 73;
        end
        default: begin
          gap_pct   = 18;
          stall_pct = 18;
        end
      endcase
      first  = sb.n_bytes;
      paused = 1'b0;
      while (sb.n_bytes - first < PHASE_BYTES) begin
        send_random_command();
        // halfway through, hold off until the result queue is empty
        if (!paused && sb.n_bytes - first >= PHASE_BYTES / 2) begin
          paused = 1'b1;
          drain();
        end
      end
      drain();
    end

    repeat (4) @(posedge clk);
    $display("%0d bytes over %0d gain settings and four idle patterns, %0d commands ended",
             sb.n_bytes, NUM_PHASES + 1, sb.n_done);
    $display("%0d results checked, %0d gain steps clamped, %0d field errors",
             sb.n_checked, sb.n_clamped, sb.errors);
    if (sb.errors == 0) begin
      $display("remote_command_parser_core: match");
    end else begin
      $display("remote_command_parser_core: mismatch");
    end
    $finish;
  end

endmodule
